@@ hdl/crem_pkg.sv @@
// ----------------------------------------------------------------------------
// crem_pkg
// Shared constants, state types and the power-of-ten table for the chunked
// decimal remainder block.
// ----------------------------------------------------------------------------
package crem_pkg;

	localparam int CHUNK_DIGITS_DEF = 16;
	localparam int DIVISOR_BITS_DEF = 10;
	localparam int CHUNK_W          = 54;
	localparam int CFG_W            = 10;
	localparam int REM_W            = 10;
	localparam int IN_TDATA_W       = 56;
	localparam int OUT_TDATA_W      = 16;
	localparam int POW_W            = 64;
	localparam int POW_IDX_W        = 5;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_RED,
		SC_MUL
	} sc_state_t;

	function automatic logic [POW_W-1:0] pow10_f(input logic [POW_IDX_W-1:0] k);
		logic [POW_W-1:0] p;
		case (k)
			5'd0:    p = 64'd1;
			5'd1:    p = 64'd10;
			5'd2:    p = 64'd100;
			5'd3:    p = 64'd1000;
			5'd4:    p = 64'd10000;
			5'd5:    p = 64'd100000;
			5'd6:    p = 64'd1000000;
			5'd7:    p = 64'd10000000;
			5'd8:    p = 64'd100000000;
			5'd9:    p = 64'd1000000000;
			5'd10:   p = 64'd10000000000;
			5'd11:   p = 64'd100000000000;
			5'd12:   p = 64'd1000000000000;
			5'd13:   p = 64'd10000000000000;
			5'd14:   p = 64'd100000000000000;
			5'd15:   p = 64'd1000000000000000;
			5'd16:   p = 64'd10000000000000000;
			5'd17:   p = 64'd100000000000000000;
			5'd18:   p = 64'd1000000000000000000;
			5'd19:   p = 64'd10000000000000000000;
			default: p = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return p;
	endfunction

endpackage

@@ hdl/chunked_decimal_remainder_top.sv @@
// ----------------------------------------------------------------------------
// chunked_decimal_remainder_top
// Running remainder of a long decimal number, fed as chunks, modulo a
// configured divisor.
// ----------------------------------------------------------------------------
// One beat at a time: a new chunk is accepted only after the current one has
// finished and its result has gone into the output register. The pace is set
// by the slower of two units that run alongside: the scale unit, which reduces
// the stored remainder one bit per cycle and then spends four compare-subtract
// steps per decimal digit on the multiply by ten, and the bit-serial reduction
// of the chunk itself. A finished result waits in the output register while the
// next chunk is already accepted.
module chunked_decimal_remainder_top #(
	parameter int CHUNK_DIGITS = crem_pkg::CHUNK_DIGITS_DEF,
	parameter int DIVISOR_BITS = crem_pkg::DIVISOR_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [crem_pkg::CFG_W-1:0]       cfg_wdata,   // divisor
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [crem_pkg::IN_TDATA_W-1:0]  s_tdata,     // [53:0] chunk_value
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [crem_pkg::OUT_TDATA_W-1:0] m_tdata,     // [9:0] running_remainder,
	                                                      // [10] is_divisible
	output logic                             m_tlast
);
	import crem_pkg::*;

	localparam logic [POW_W-1:0] CHUNK_LIM = pow10_f(POW_IDX_W'(CHUNK_DIGITS)) - 64'd1;
	localparam int PAD_W = OUT_TDATA_W - REM_W - 1;

	state_t st_q, st_d;

	logic [DIVISOR_BITS-1:0] div_q, div_eff, pr_q, out_rem_q, ser_rem, sc_rem, r;
	logic [DIVISOR_BITS:0]   sum;
	logic [CHUNK_W-1:0]      chunk_in, chunk_sat;
	logic                    accept, finish, ser_done, sc_done, out_free;
	logic                    last_q, out_last_q, out_div_q, m_tvalid_q;

	assign chunk_in  = s_tdata[CHUNK_W-1:0];
	assign chunk_sat = (POW_W'(chunk_in) > CHUNK_LIM) ? CHUNK_W'(CHUNK_LIM) : chunk_in;
	assign div_eff   = (div_q == '0) ? DIVISOR_BITS'(1) : div_q;
	assign s_tready  = (st_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign finish    = (st_q == ST_RUN) && ser_done && sc_done && out_free;

	crem_modser #(
		.DIVISOR_BITS(DIVISOR_BITS)
	) u_modser (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.value (chunk_sat),
		.m     (div_eff),
		.done  (ser_done),
		.rem   (ser_rem)
	);

	crem_scale #(
		.CHUNK_DIGITS(CHUNK_DIGITS),
		.DIVISOR_BITS(DIVISOR_BITS)
	) u_scale (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.pr    (pr_q),
		.chunk (chunk_sat),
		.m     (div_eff),
		.done  (sc_done),
		.rem   (sc_rem)
	);

	assign sum = {1'b0, sc_rem} + {1'b0, ser_rem};
	assign r   = (sum >= {1'b0, div_eff}) ? DIVISOR_BITS'(sum - {1'b0, div_eff}) :
		DIVISOR_BITS'(sum);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					st_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (finish) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			div_q      <= DIVISOR_BITS'(2);
			pr_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				div_q <= DIVISOR_BITS'(cfg_wdata);
			end
			if (finish) begin
				pr_q       <= last_q ? '0 : r;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= s_tlast;
		end
		if (finish) begin
			out_rem_q  <= r;
			out_div_q  <= (r == '0);
			out_last_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_div_q, REM_W'(out_rem_q)};
	assign m_tlast  = out_last_q;

	busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken again before the chunk was finished");

	rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_rem_q < div_eff))
		else $error("remainder not below divisor");

	flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_div_q == (out_rem_q == '0)))
		else $error("divisible flag disagrees with remainder");

	result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(st_q == ST_RUN))
		else $error("result raised outside a running chunk");

endmodule

@@ hdl/crem_modser.sv @@
// ----------------------------------------------------------------------------
// crem_modser
// Bit-serial reduction of a chunk modulo the divisor, one bit per cycle,
// most significant bit first.
// ----------------------------------------------------------------------------
module crem_modser #(
	parameter int DIVISOR_BITS = crem_pkg::DIVISOR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [crem_pkg::CHUNK_W-1:0] value,
	input  logic [DIVISOR_BITS-1:0]      m,
	output logic                         done,
	output logic [DIVISOR_BITS-1:0]      rem
);
	import crem_pkg::*;

	localparam int CNT_W = $clog2(CHUNK_W + 1);

	logic [CHUNK_W-1:0]      sh_q;
	logic [DIVISOR_BITS-1:0] acc_q;
	logic [DIVISOR_BITS-1:0] acc_d;
	logic [DIVISOR_BITS:0]   t;
	logic [CNT_W-1:0]        cnt_q;

	assign t     = {acc_q, sh_q[CHUNK_W-1]};
	assign acc_d = (t >= {1'b0, m}) ? DIVISOR_BITS'(t - {1'b0, m}) : DIVISOR_BITS'(t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(CHUNK_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			sh_q  <= sh_q << 1;
			acc_q <= acc_d;
		end
	end

	assign done = (cnt_q == '0);
	assign rem  = acc_q;

endmodule

@@ hdl/crem_scale.sv @@
// ----------------------------------------------------------------------------
// crem_scale
// Reduces the stored remainder bit-serially, then multiplies it by ten once
// per decimal digit of the chunk with a shared double/add step.
// ----------------------------------------------------------------------------
module crem_scale #(
	parameter int CHUNK_DIGITS = crem_pkg::CHUNK_DIGITS_DEF,
	parameter int DIVISOR_BITS = crem_pkg::DIVISOR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DIVISOR_BITS-1:0]      pr,
	input  logic [crem_pkg::CHUNK_W-1:0] chunk,
	input  logic [DIVISOR_BITS-1:0]      m,
	output logic                         done,
	output logic [DIVISOR_BITS-1:0]      rem
);
	import crem_pkg::*;

	localparam int BCNT_W = $clog2(DIVISOR_BITS + 1);
	localparam int K_W    = $clog2(CHUNK_DIGITS + 1);
	localparam logic [1:0] SUB_FIRST = 2'd0;
	localparam logic [1:0] SUB_ADD   = 2'd2;
	localparam logic [1:0] SUB_LAST  = 2'd3;

	sc_state_t st_q, st_d;

	logic [DIVISOR_BITS-1:0] a_q, a_d, x_q, x_d, sh_q, sh_d, a_red;
	logic [DIVISOR_BITS:0]   t;
	logic [BCNT_W-1:0]       bcnt_q, bcnt_d;
	logic [1:0]              sub_q, sub_d;
	logic [K_W-1:0]          k_q, k_d;
	logic [CHUNK_W-1:0]      chunk_q, chunk_d;
	logic                    more_digits;

	assign t = (st_q == SC_RED) ? {a_q, sh_q[DIVISOR_BITS-1]} :
		(sub_q == SUB_ADD) ? ({1'b0, a_q} + {1'b0, x_q}) : {a_q, 1'b0};
	assign a_red = (t >= {1'b0, m}) ? DIVISOR_BITS'(t - {1'b0, m}) : DIVISOR_BITS'(t);
	assign more_digits = (POW_W'(chunk_q) >= pow10_f(POW_IDX_W'(k_q)));

	always_comb begin
		st_d    = st_q;
		a_d     = a_q;
		x_d     = x_q;
		sh_d    = sh_q;
		bcnt_d  = bcnt_q;
		sub_d   = sub_q;
		k_d     = k_q;
		chunk_d = chunk_q;
		case (st_q)
			SC_IDLE: begin
				if (start) begin
					st_d    = SC_RED;
					a_d     = '0;
					sh_d    = pr;
					bcnt_d  = BCNT_W'(DIVISOR_BITS);
					chunk_d = chunk;
				end
			end
			SC_RED: begin
				a_d    = a_red;
				sh_d   = sh_q << 1;
				bcnt_d = bcnt_q - BCNT_W'(1);
				if (bcnt_q == BCNT_W'(1)) begin
					st_d  = SC_MUL;
					sub_d = SUB_FIRST;
					k_d   = K_W'(1);
				end
			end
			SC_MUL: begin
				a_d   = a_red;
				sub_d = sub_q + 2'd1;
				if (sub_q == SUB_FIRST) begin
					x_d = a_q;
				end
				if (sub_q == SUB_LAST) begin
					if (more_digits) begin
						k_d = k_q + K_W'(1);
					end else begin
						st_d = SC_IDLE;
					end
				end
			end
			default: begin
				st_d = SC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SC_IDLE;
			bcnt_q <= '0;
			sub_q  <= SUB_FIRST;
			k_q    <= '0;
		end else begin
			st_q   <= st_d;
			bcnt_q <= bcnt_d;
			sub_q  <= sub_d;
			k_q    <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q     <= a_d;
		x_q     <= x_d;
		sh_q    <= sh_d;
		chunk_q <= chunk_d;
	end

	assign done = (st_q == SC_IDLE);
	assign rem  = a_q;

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != SC_IDLE) |-> (a_q < m))
		else $error("scale accumulator not reduced below divisor");

	x_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == SC_MUL && sub_q != SUB_FIRST) |-> (x_q < m))
		else $error("scale addend not reduced below divisor");

	start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == SC_IDLE && start) |=> (st_q == SC_RED && a_q == '0))
		else $error("scale did not enter the reduction phase on start");

endmodule
